[src/ptp_pkg.sv]
package ptp_pkg;

	// Field and register widths
	localparam int POS_W  = 12;
	localparam int SIZE_W = 13;
	localparam int FPS_W  = 8;
	localparam int FOV_W  = 8;
	localparam int OFF_W  = 12;
	localparam int ANG_W  = 17;
	localparam int IDX_W  = 3;
	localparam int CFG_W  = 13;

	// Datapath widths
	localparam int MISS_W   = 9;
	localparam int VEL_W    = 22;
	localparam int T_SHIFT  = 7;
	localparam int T_W      = SIZE_W + 2 + T_SHIFT;
	localparam int AIM_W    = VEL_W + 1;
	localparam int PROD_W   = 32;
	localparam int DIV_W    = PROD_W - 1;
	localparam int DEN_W    = SIZE_W;
	localparam int CNT_W    = $clog2(DIV_W + 1);
	localparam int PC_W     = 5;

	localparam logic [MISS_W-1:0] MISS_MAX = '1;
	localparam longint VEL_HI  = (64'sd1 <<< (VEL_W - 1)) - 64'sd1;
	localparam longint VEL_LO  = -VEL_HI - 64'sd1;
	localparam longint ANG_MAX = 46080;

	// Register reset values
	localparam logic [FPS_W-1:0]  FPS_RST    = FPS_W'(30);
	localparam logic [FOV_W-1:0]  FOV_RST    = FOV_W'(60);
	localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(640);
	localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(480);

	typedef enum logic [IDX_W-1:0] {
		REG_FPS,
		REG_FOV,
		REG_PREDICT,
		REG_GAP,
		REG_WIDTH,
		REG_HEIGHT,
		REG_OFF_X,
		REG_OFF_Y
	} reg_idx_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_MUL_VM,
		OP_NUM_TP,
		OP_NUM_T,
		OP_NUM_P,
		OP_DIV_M1,
		OP_DIV_M,
		OP_DIV_SIZE,
		OP_VEL_QUO,
		OP_VEL_ADD,
		OP_AIM_TV,
		OP_MISS,
		OP_PLAIN,
		OP_ADD_OFF,
		OP_MUL_FOV,
		OP_OUT
	} op_t;

	// Hold the step while the condition stands
	typedef enum logic [1:0] {
		W_NONE,
		W_INPUT,
		W_DIV,
		W_OUT
	} hold_t;

	typedef enum logic [2:0] {
		JC_NONE,
		JC_ALWAYS,
		JC_MISS,
		JC_NO_PRED,
		JC_NO_GAP
	} cond_t;

	typedef logic [PC_W-1:0] pc_t;

	typedef struct packed {
		op_t   op;
		hold_t hold;
		cond_t jc;
		pc_t   target;
	} uword_t;

	localparam pc_t S_ACCEPT    = PC_W'(0);
	localparam pc_t S_TEST_DET  = PC_W'(1);
	localparam pc_t S_TEST_PRED = PC_W'(2);
	localparam pc_t S_MUL_VM    = PC_W'(3);
	localparam pc_t S_GAP_NUM   = PC_W'(4);
	localparam pc_t S_GAP_DIV   = PC_W'(5);
	localparam pc_t S_GAP_WAIT  = PC_W'(6);
	localparam pc_t S_GAP_VEL   = PC_W'(7);
	localparam pc_t S_ACC_NUM   = PC_W'(8);
	localparam pc_t S_ACC_DIV   = PC_W'(9);
	localparam pc_t S_ACC_WAIT  = PC_W'(10);
	localparam pc_t S_ACC_VEL   = PC_W'(11);
	localparam pc_t S_AIM_TV    = PC_W'(12);
	localparam pc_t S_MISS      = PC_W'(13);
	localparam pc_t S_PLAIN     = PC_W'(14);
	localparam pc_t S_ADD_OFF   = PC_W'(15);
	localparam pc_t S_MUL_FOV   = PC_W'(16);
	localparam pc_t S_ANG_NUM   = PC_W'(17);
	localparam pc_t S_ANG_DIV   = PC_W'(18);
	localparam pc_t S_ANG_WAIT  = PC_W'(19);
	localparam pc_t S_OUT       = PC_W'(20);

	// Control store
	function automatic uword_t ucode(input pc_t pc);
		uword_t w;
		unique case (pc)
			S_ACCEPT:    w = '{OP_ACCEPT,   W_INPUT, JC_NONE,    S_ACCEPT};
			S_TEST_DET:  w = '{OP_NOP,      W_NONE,  JC_MISS,    S_MISS};
			S_TEST_PRED: w = '{OP_NOP,      W_NONE,  JC_NO_PRED, S_PLAIN};
			S_MUL_VM:    w = '{OP_MUL_VM,   W_NONE,  JC_NO_GAP,  S_ACC_NUM};
			S_GAP_NUM:   w = '{OP_NUM_TP,   W_NONE,  JC_NONE,    S_ACCEPT};
			S_GAP_DIV:   w = '{OP_DIV_M1,   W_NONE,  JC_NONE,    S_ACCEPT};
			S_GAP_WAIT:  w = '{OP_NOP,      W_DIV,   JC_NONE,    S_ACCEPT};
			S_GAP_VEL:   w = '{OP_VEL_QUO,  W_NONE,  JC_ALWAYS,  S_AIM_TV};
			S_ACC_NUM:   w = '{OP_NUM_T,    W_NONE,  JC_NONE,    S_ACCEPT};
			S_ACC_DIV:   w = '{OP_DIV_M,    W_NONE,  JC_NONE,    S_ACCEPT};
			S_ACC_WAIT:  w = '{OP_NOP,      W_DIV,   JC_NONE,    S_ACCEPT};
			S_ACC_VEL:   w = '{OP_VEL_ADD,  W_NONE,  JC_NONE,    S_ACCEPT};
			S_AIM_TV:    w = '{OP_AIM_TV,   W_NONE,  JC_ALWAYS,  S_ADD_OFF};
			S_MISS:      w = '{OP_MISS,     W_NONE,  JC_ALWAYS,  S_ADD_OFF};
			S_PLAIN:     w = '{OP_PLAIN,    W_NONE,  JC_NONE,    S_ACCEPT};
			S_ADD_OFF:   w = '{OP_ADD_OFF,  W_NONE,  JC_NONE,    S_ACCEPT};
			S_MUL_FOV:   w = '{OP_MUL_FOV,  W_NONE,  JC_NONE,    S_ACCEPT};
			S_ANG_NUM:   w = '{OP_NUM_P,    W_NONE,  JC_NONE,    S_ACCEPT};
			S_ANG_DIV:   w = '{OP_DIV_SIZE, W_NONE,  JC_NONE,    S_ACCEPT};
			S_ANG_WAIT:  w = '{OP_NOP,      W_DIV,   JC_NONE,    S_ACCEPT};
			S_OUT:       w = '{OP_OUT,      W_OUT,   JC_ALWAYS,  S_ACCEPT};
			default:     w = '{OP_NOP,      W_NONE,  JC_ALWAYS,  S_ACCEPT};
		endcase
		return w;
	endfunction

	function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [PROD_W-1:0] v);
		logic signed [VEL_W-1:0] r;
		if (v > VEL_HI)
			r = VEL_W'(VEL_HI);
		else if (v < VEL_LO)
			r = VEL_W'(VEL_LO);
		else
			r = v[VEL_W-1:0];
		return r;
	endfunction

	function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [PROD_W-1:0] v);
		logic signed [ANG_W-1:0] r;
		if (v > ANG_MAX)
			r = ANG_W'(ANG_MAX);
		else if (v < -ANG_MAX)
			r = ANG_W'(-ANG_MAX);
		else
			r = v[ANG_W-1:0];
		return r;
	endfunction

endpackage

[src/ptp_div.sv]
module ptp_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [ptp_pkg::PROD_W-1:0] num,
	input  logic        [ptp_pkg::DEN_W-1:0]  den,
	output logic signed [ptp_pkg::PROD_W-1:0] quo,
	output logic                               last
);
	import ptp_pkg::*;

	logic [DIV_W-1:0]  dvd_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              neg;
	logic [PROD_W-1:0] load_sum;
	logic [DEN_W:0]    trial;
	logic              fits;
	logic signed [PROD_W-1:0] qext;

	// Magnitude plus half the divisor gives round-half-away once the sign is put back
	assign neg      = num[PROD_W-1];
	assign load_sum = (neg ? ~num : num) + {{(PROD_W-1){1'b0}}, neg}
		+ {{(PROD_W-DEN_W){1'b0}}, den >> 1};

	assign trial = {rem_q, dvd_q[DIV_W-1]} - {1'b0, den_q};
	assign fits  = ~trial[DEN_W];

	assign qext = $signed({1'b0, dvd_q});
	assign quo  = neg_q ? -qext : qext;
	assign last = (cnt_q == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DIV_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= load_sum[DIV_W-1:0];
			rem_q <= '0;
			den_q <= den;
			neg_q <= neg;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? trial[DEN_W-1:0] : {rem_q[DEN_W-2:0], dvd_q[DIV_W-1]};
			dvd_q <= {dvd_q[DIV_W-2:0], fits};
		end
	end

endmodule

[src/pan_tilt_target_predictor.sv]
// Pan/tilt target predictor. One transfer in per camera frame (detect flag and target
// pixel), one transfer out per frame (horizontal and vertical aim angle, signed Q8.8
// degrees, clamped to +-180). A small control store sequences a shared datapath with
// one lane for each axis; both lanes run the same step. The result is loaded once the
// angle division ends when the target is missed or detected without prediction, and
// after a velocity division as well when the velocity is updated; the load waits while
// the output register stays full, and the next input transfer can follow in the cycle
// after the load. Each lane has a radix-2 divider, used once for the angle and once
// more for a velocity update. One frame is in flight at a time; the next input transfer
// is taken once the result is loaded, even while that result still waits to be taken.
// Registers may be written only while no frame is in flight.
module pan_tilt_target_predictor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              detected,
	input  logic        [ptp_pkg::POS_W-1:0]  pos_x,
	input  logic        [ptp_pkg::POS_W-1:0]  pos_y,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [ptp_pkg::ANG_W-1:0]  angle_x,
	output logic signed [ptp_pkg::ANG_W-1:0]  angle_y,
	input  logic                              cfg_we,
	input  logic        [ptp_pkg::IDX_W-1:0]  cfg_index,
	input  logic        [ptp_pkg::CFG_W-1:0]  cfg_data
);
	import ptp_pkg::*;

	// Configuration registers
	logic [FPS_W-1:0]         fps_q;
	logic [FOV_W-1:0]         fov_q;
	logic                     predict_q;
	logic                     gap_q;
	logic [SIZE_W-1:0]        width_q;
	logic [SIZE_W-1:0]        height_q;
	logic signed [OFF_W-1:0]  off_x_q;
	logic signed [OFF_W-1:0]  off_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fps_q     <= FPS_RST;
			fov_q     <= FOV_RST;
			predict_q <= 1'b0;
			gap_q     <= 1'b1;
			width_q   <= WIDTH_RST;
			height_q  <= HEIGHT_RST;
			off_x_q   <= '0;
			off_y_q   <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FPS:     fps_q     <= cfg_data[FPS_W-1:0];
				REG_FOV:     fov_q     <= cfg_data[FOV_W-1:0];
				REG_PREDICT: predict_q <= cfg_data[0];
				REG_GAP:     gap_q     <= cfg_data[0];
				REG_WIDTH:   width_q   <= cfg_data[SIZE_W-1:0];
				REG_HEIGHT:  height_q  <= cfg_data[SIZE_W-1:0];
				REG_OFF_X:   off_x_q   <= $signed(cfg_data[OFF_W-1:0]);
				REG_OFF_Y:   off_y_q   <= $signed(cfg_data[OFF_W-1:0]);
			endcase
		end
	end

	// Sequencer
	pc_t                 pc_q;
	uword_t              uw;
	logic                hold;
	logic                take;
	logic                go;
	logic                det_q;
	logic                first_q;
	logic [MISS_W-1:0]   miss_q;
	logic [MISS_W-1:0]   m;
	logic [MISS_W-1:0]   miss_inc;
	logic                vel_clear;
	logic                out_valid_q;
	logic                div_start;
	logic [1:0]          div_last;

	assign uw = ucode(pc_q);

	always_comb begin
		unique case (uw.hold)
			W_NONE:  hold = 1'b0;
			W_INPUT: hold = ~in_valid;
			W_DIV:   hold = ~(&div_last);
			W_OUT:   hold = out_valid_q & out_stall;
			default: hold = 1'b0;
		endcase
	end

	always_comb begin
		unique case (uw.jc)
			JC_NONE:    take = 1'b0;
			JC_ALWAYS:  take = 1'b1;
			JC_MISS:    take = ~det_q;
			JC_NO_PRED: take = ~(predict_q & ~first_q);
			JC_NO_GAP:  take = ~((miss_q > MISS_W'(1)) & gap_q);
			default:    take = 1'b0;
		endcase
	end

	assign go        = ~hold;
	assign in_stall  = (uw.op != OP_ACCEPT);
	assign out_valid = out_valid_q;
	assign div_start = go & (uw.op == OP_DIV_M1 || uw.op == OP_DIV_M || uw.op == OP_DIV_SIZE);

	assign m         = (miss_q == '0) ? MISS_W'(1) : miss_q;
	assign miss_inc  = (miss_q == MISS_MAX) ? miss_q : miss_q + MISS_W'(1);
	assign vel_clear = (miss_inc > {1'b0, fps_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= S_ACCEPT;
			det_q       <= 1'b0;
			first_q     <= 1'b1;
			miss_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!hold)
				pc_q <= take ? uw.target : pc_q + PC_W'(1);
			if (go) begin
				unique case (uw.op)
					OP_ACCEPT: det_q <= detected;
					OP_AIM_TV: miss_q <= MISS_W'(1);
					OP_PLAIN: begin
						miss_q  <= MISS_W'(1);
						first_q <= 1'b0;
					end
					OP_MISS: begin
						miss_q  <= miss_inc;
						first_q <= 1'b1;
					end
					default: ;
				endcase
			end
			if (go && uw.op == OP_OUT)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Axis lanes: index 0 is horizontal, 1 is vertical
	logic        [POS_W-1:0]  pos_l  [2];
	logic        [SIZE_W-1:0] size_l [2];
	logic signed [OFF_W-1:0]  off_l  [2];
	logic signed [ANG_W-1:0]  ang_l  [2];

	assign pos_l[0]  = pos_x;
	assign pos_l[1]  = pos_y;
	assign size_l[0] = width_q;
	assign size_l[1] = height_q;
	assign off_l[0]  = off_x_q;
	assign off_l[1]  = off_y_q;
	assign angle_x   = ang_l[0];
	assign angle_y   = ang_l[1];

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic signed [T_W-1:0]        t_q;
		logic signed [VEL_W-1:0]      vel_q;
		logic signed [AIM_W-1:0]      aim_q;
		logic signed [PROD_W-1:0]     prod_q;
		logic signed [PROD_W-1:0]     num_q;
		logic signed [ANG_W-1:0]      ang_q;

		logic signed [T_W-T_SHIFT-1:0] diff;
		logic signed [T_W-1:0]        t_new;
		logic signed [PROD_W-1:0]     mul_vm;
		logic signed [PROD_W-1:0]     mul_fov;
		logic signed [PROD_W-1:0]     num_tp;
		logic signed [PROD_W-1:0]     vel_add;
		logic signed [AIM_W-1:0]      aim_tv;
		logic signed [AIM_W-1:0]      aim_off;
		logic        [DEN_W-1:0]      den;
		logic signed [PROD_W-1:0]     quo;

		// Offset from the screen center in half pixels, scaled to Q.8 pixels
		assign diff    = $signed({2'b00, pos_l[l], 1'b0}) - $signed({2'b00, size_l[l]});
		assign t_new   = {diff, {T_SHIFT{1'b0}}};
		assign mul_vm  = vel_q * $signed({1'b0, m});
		assign mul_fov = aim_q * $signed({1'b0, fov_q});
		assign num_tp  = t_q + prod_q;
		assign vel_add = quo + vel_q;
		assign aim_tv  = t_q + vel_q;
		assign aim_off = aim_q + $signed({off_l[l], 8'h00});

		always_comb begin
			unique case (uw.op)
				OP_DIV_M1: den = DEN_W'(m) + DEN_W'(1);
				OP_DIV_M:  den = DEN_W'(m);
				default:   den = (size_l[l] == '0) ? DEN_W'(1) : size_l[l];
			endcase
		end

		ptp_div u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (div_start),
			.num    (num_q),
			.den    (den),
			.quo    (quo),
			.last   (div_last[l])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vel_q <= '0;
			end else if (go) begin
				unique case (uw.op)
					OP_VEL_QUO: vel_q <= sat_vel(quo);
					OP_VEL_ADD: vel_q <= sat_vel(vel_add);
					OP_MISS: begin
						if (vel_clear)
							vel_q <= '0;
					end
					default: ;
				endcase
			end
		end

		always_ff @(posedge clk) begin
			if (go) begin
				unique case (uw.op)
					OP_ACCEPT:  t_q    <= t_new;
					OP_MUL_VM:  prod_q <= mul_vm;
					OP_NUM_TP:  num_q  <= num_tp;
					OP_NUM_T:   num_q  <= {{(PROD_W-T_W){t_q[T_W-1]}}, t_q};
					OP_NUM_P:   num_q  <= prod_q;
					OP_AIM_TV:  aim_q  <= aim_tv;
					OP_MISS:    aim_q  <= vel_clear ? '0 : {vel_q[VEL_W-1], vel_q};
					OP_PLAIN:   aim_q  <= {{(AIM_W-T_W){t_q[T_W-1]}}, t_q};
					OP_ADD_OFF: aim_q  <= aim_off;
					OP_MUL_FOV: prod_q <= mul_fov;
					OP_OUT:     ang_q  <= sat_ang(quo);
					default: ;
				endcase
			end
		end

		assign ang_l[l] = ang_q;
	end

endmodule

[src/ptp_checker.sv]
module ptp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [ptp_pkg::ANG_W-1:0]  angle_x,
	input logic signed [ptp_pkg::ANG_W-1:0]  angle_y
);
	import ptp_pkg::*;

	logic [1:0] pend_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = in_valid & ~in_stall;
	assign out_xfer = out_valid & ~out_stall;

	// Frames taken in whose result has not been transferred out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else if (in_xfer && !out_xfer)
			pend_q <= pend_q + 2'd1;
		else if (!in_xfer && out_xfer)
			pend_q <= pend_q - 2'd1;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(angle_x) && $stable(angle_y))
		else $error("result changed while stalled");

	a_ang_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> angle_x <= ANG_MAX && angle_x >= -ANG_MAX
			&& angle_y <= ANG_MAX && angle_y >= -ANG_MAX)
		else $error("angle outside clamp range");

	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("input taken while a frame is in flight");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result without a frame taken in");

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd2 |-> in_stall)
		else $error("third frame accepted");

endmodule

bind pan_tilt_target_predictor ptp_checker u_checker (.*);
